>>> src/bqda_pkg.sv
// bqda_pkg: shared types, constants and the operand decoder of the quire dot accumulator
// depends on nothing; imported by the front, queue, back and top modules of the block
package bqda_pkg;

    localparam int CODE_W      = 16;
    localparam int MANT_W      = 11;
    localparam int PROD_W      = 2 * MANT_W;
    localparam int EXP_W       = 8;
    localparam int LIMB_W      = 64;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                     sign;
        logic                     zero;
        logic [MANT_W-1:0]        mant;
        logic signed [EXP_W-1:0]  expo;
    } dec_t;

    typedef struct packed {
        logic              neg;
        logic              drop;
        logic              clear;
        logic              emit;
        logic [MANT_W-1:0] mant_a;
        logic [MANT_W-1:0] mant_b;
    } item_t;

    // value = mant * 2^expo, es = 3, unbounded regime
    function automatic dec_t decode(input logic [CODE_W-1:0] code);
        dec_t                    d;
        logic [CODE_W-2:0]       r;
        logic [CODE_W-2:0]       norm;
        logic [CODE_W-2:0]       t;
        logic                    lead;
        logic                    stop;
        logic [3:0]              rs;
        logic [3:0]              rem;
        logic [3:0]              fw;
        logic [2:0]              ev;
        logic signed [EXP_W-1:0] rs_s;
        logic signed [EXP_W-1:0] k;
        r    = code[CODE_W-1] ? (15'd0 - code[CODE_W-2:0]) : code[CODE_W-2:0];
        lead = r[CODE_W-2];
        norm = lead ? ~r : r;
        rs   = 4'd15;
        stop = 1'b0;
        for (int i = CODE_W - 2; i >= 0; i--)
        begin
            if (!stop && norm[i])
            begin
                rs   = 4'(14 - i);
                stop = 1'b1;
            end
        end
        rem    = (rs >= 4'd14) ? 4'd0 : 4'd14 - rs;
        fw     = (rem > 4'd3) ? rem - 4'd3 : 4'd0;
        t      = r << ({1'b0, rs} + 5'd1);
        ev     = t[14:12];
        rs_s   = $signed({4'b0, rs});
        k      = lead ? rs_s - 8'sd1 : -rs_s;
        d.sign = code[CODE_W-1];
        d.zero = (r == '0);
        d.mant = {1'b1, t[11:2]} >> (4'd10 - fw);
        d.expo = (k <<< 3) + $signed({5'b0, ev}) - $signed({4'b0, fw});
        return d;
    endfunction

endpackage

>>> src/bqda_front.sv
// bqda_front: input register stage, decodes both codes and computes the quire bit position
// depends on bqda_pkg
module bqda_front #(
    parameter int QUIRE_FRAC_BITS = 96,
    parameter int QUIRE_W         = 256,
    parameter int POS_W           = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bqda_pkg::CODE_W-1:0]       a_code,
    input  logic [bqda_pkg::CODE_W-1:0]       b_code,
    input  logic                              clear_first,
    input  logic                              emit_after,
    input  logic                              in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bqda_pkg::item_t                   out_item,
    output logic [POS_W-1:0]                  out_pos
);
    import bqda_pkg::*;

    localparam int SHW = $clog2(QUIRE_W + QUIRE_FRAC_BITS + 256) + 1;

    dec_t                  da;
    dec_t                  db;
    logic signed [SHW-1:0] shift;
    logic                  take;
    logic                  valid_reg;
    logic                  valid_next;
    item_t                 item_reg;
    item_t                 item_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_pos   = pos_reg;

    always_comb
    begin
        da    = decode(a_code);
        db    = decode(b_code);
        shift = SHW'(da.expo) + SHW'(db.expo) + SHW'(QUIRE_FRAC_BITS);
        item_next.neg    = da.sign ^ db.sign;
        item_next.drop   = da.zero || db.zero || (shift < 0) || (shift >= SHW'(QUIRE_W));
        item_next.clear  = clear_first;
        item_next.emit   = emit_after;
        item_next.mant_a = da.mant;
        item_next.mant_b = db.mant;
        pos_next   = shift[POS_W-1:0];
        valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

>>> src/bqda_queue.sv
// bqda_queue: small fifo between the decode front and the accumulate back
// depends on bqda_pkg
module bqda_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import bqda_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> src/bqda_back.sv
// bqda_back: multiply, place and negate, quire accumulate and limb serializer
// depends on bqda_pkg
module bqda_back #(
    parameter int QUIRE_LIMBS = 4,
    parameter int QUIRE_W     = 256,
    parameter int POS_W       = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bqda_pkg::item_t               in_item,
    input  logic [POS_W-1:0]              in_pos,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bqda_pkg::LIMB_W-1:0]   limb_value,
    output logic [1:0]                    limb_index,
    output logic                          last_limb
);
    import bqda_pkg::*;

    localparam int CNT_W = $clog2(QUIRE_LIMBS);

    logic               back_en;
    logic               emit_free;
    logic               out_fire;
    logic               out_last;
    logic [QUIRE_W-1:0] placed;
    logic [QUIRE_W-1:0] quire_sum;

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_neg_reg, s1_neg_next;
    logic               s1_drop_reg, s1_drop_next;
    logic               s1_clear_reg, s1_clear_next;
    logic               s1_emit_reg, s1_emit_next;
    logic [PROD_W-1:0]  s1_prod_reg, s1_prod_next;
    logic [POS_W-1:0]   s1_pos_reg, s1_pos_next;

    logic               s2_valid_reg, s2_valid_next;
    logic               s2_clear_reg, s2_clear_next;
    logic               s2_emit_reg, s2_emit_next;
    logic [QUIRE_W-1:0] s2_add_reg, s2_add_next;

    logic [QUIRE_W-1:0] quire_reg, quire_next;
    logic [QUIRE_W-1:0] snap_reg, snap_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;

    assign out_fire   = out_valid_reg && out_ready;
    assign out_last   = (cnt_reg == CNT_W'(QUIRE_LIMBS - 1));
    assign emit_free  = !out_valid_reg || (out_fire && out_last);
    assign back_en    = !(s2_valid_reg && s2_emit_reg && !emit_free);
    assign in_ready   = back_en;
    assign out_valid  = out_valid_reg;
    assign limb_value = snap_reg[LIMB_W-1:0];
    assign limb_index = cnt_reg[1:0];
    assign last_limb  = out_last;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_neg_next    = s1_neg_reg;
        s1_drop_next   = s1_drop_reg;
        s1_clear_next  = s1_clear_reg;
        s1_emit_next   = s1_emit_reg;
        s1_prod_next   = s1_prod_reg;
        s1_pos_next    = s1_pos_reg;
        s2_valid_next  = s2_valid_reg;
        s2_clear_next  = s2_clear_reg;
        s2_emit_next   = s2_emit_reg;
        s2_add_next    = s2_add_reg;
        quire_next     = quire_reg;
        snap_next      = snap_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        placed    = QUIRE_W'(s1_prod_reg) << s1_pos_reg;
        quire_sum = (s2_clear_reg ? '0 : quire_reg) + s2_add_reg;

        if (back_en)
        begin
            s1_valid_next = in_valid;
            s1_neg_next   = in_item.neg;
            s1_drop_next  = in_item.drop;
            s1_clear_next = in_item.clear;
            s1_emit_next  = in_item.emit;
            s1_prod_next  = PROD_W'(in_item.mant_a) * PROD_W'(in_item.mant_b);
            s1_pos_next   = in_pos;
            s2_valid_next = s1_valid_reg;
            s2_clear_next = s1_clear_reg;
            s2_emit_next  = s1_emit_reg;
            s2_add_next   = s1_drop_reg ? '0
                          : (placed ^ {QUIRE_W{s1_neg_reg}}) + QUIRE_W'(s1_neg_reg);
        end

        if (out_fire)
        begin
            snap_next = snap_reg >> LIMB_W;
            cnt_next  = cnt_reg + 1'b1;
            if (out_last)
            begin
                out_valid_next = 1'b0;
            end
        end

        if (back_en && s2_valid_reg)
        begin
            quire_next = quire_sum;
            if (s2_emit_reg)
            begin
                snap_next      = quire_sum;
                cnt_next       = '0;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            quire_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            quire_reg     <= quire_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg   <= s1_neg_next;
        s1_drop_reg  <= s1_drop_next;
        s1_clear_reg <= s1_clear_next;
        s1_emit_reg  <= s1_emit_next;
        s1_prod_reg  <= s1_prod_next;
        s1_pos_reg   <= s1_pos_next;
        s2_clear_reg <= s2_clear_next;
        s2_emit_reg  <= s2_emit_next;
        s2_add_reg   <= s2_add_next;
        snap_reg     <= snap_next;
    end

endmodule

>>> src/bposit16_quire_dot_accumulator_unit.sv
// bposit16_quire_dot_accumulator_unit: top level of the posit16 quire dot accumulator
// depends on bqda_pkg, bqda_front, bqda_queue, bqda_back
//
// Takes one pair of 16-bit posit codes (es = 3) per cycle while in_ready is high, multiplies
// them exactly and adds the product into a 64*QUIRE_LIMBS bit fixed-point quire with
// QUIRE_FRAC_BITS fraction bits, wrapping modulo 2^(64*QUIRE_LIMBS). A decode stage and a
// four-entry queue feed a back end of multiply, place/negate and accumulate stages. An emit
// sends QUIRE_LIMBS limbs, least significant first, one per cycle while out_ready is high,
// from a quire-wide snapshot register shifted down by 64 bits per limb; a following emitting
// transaction waits in the back end until the last limb of the previous one is taken, and
// while it waits the back end takes no new transaction.
// No clearing pass after reset: the quire resets to zero directly.
module bposit16_quire_dot_accumulator_unit #(
    parameter int QUIRE_FRAC_BITS = 96,
    parameter int QUIRE_LIMBS     = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bqda_pkg::CODE_W-1:0]       a_code,
    input  logic [bqda_pkg::CODE_W-1:0]       b_code,
    input  logic                              clear_first,
    input  logic                              emit_after,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bqda_pkg::LIMB_W-1:0]       limb_value,
    output logic [1:0]                        limb_index,
    output logic                              last_limb
);
    import bqda_pkg::*;

    localparam int QUIRE_W = LIMB_W * QUIRE_LIMBS;
    localparam int POS_W   = $clog2(QUIRE_W);
    localparam int Q_W     = $bits(item_t) + POS_W;

    logic             fr_valid;
    logic             fr_ready;
    item_t            fr_item;
    logic [POS_W-1:0] fr_pos;
    logic [Q_W-1:0]   q_out_data;
    logic             q_valid;
    logic             q_ready;
    item_t            bk_item;
    logic [POS_W-1:0] bk_pos;

    assign {bk_item, bk_pos} = q_out_data;

    bqda_front #(
        .QUIRE_FRAC_BITS (QUIRE_FRAC_BITS),
        .QUIRE_W         (QUIRE_W),
        .POS_W           (POS_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .a_code      (a_code),
        .b_code      (b_code),
        .clear_first (clear_first),
        .emit_after  (emit_after),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_item    (fr_item),
        .out_pos     (fr_pos)
    );

    bqda_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   ({fr_item, fr_pos}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out_data)
    );

    bqda_back #(
        .QUIRE_LIMBS (QUIRE_LIMBS),
        .QUIRE_W     (QUIRE_W),
        .POS_W       (POS_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (bk_item),
        .in_pos     (bk_pos),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .limb_value (limb_value),
        .limb_index (limb_index),
        .last_limb  (last_limb)
    );

endmodule

>>> src/bqda_checker.sv
// bqda_checker: port-level assertions on the limb output sequence
// depends on bposit16_quire_dot_accumulator_unit, attached by the bind below
module bqda_checker #(
    parameter int QUIRE_LIMBS = 4
) (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] limb_value,
    input logic [1:0]  limb_index,
    input logic        last_limb
);

    // stalled limb holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(limb_value) && $stable(limb_index)
            && $stable(last_limb))
        else $error("limb changed while stalled");

    // last limb sits at the top position
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_limb |-> limb_index == 2'(QUIRE_LIMBS - 1))
        else $error("last limb at wrong position");

    // limbs of one emit follow in order
    a_limb_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_limb |=>
            out_valid && limb_index == $past(limb_index) + 2'd1)
        else $error("limb sequence broken");

    // a new emit starts from the low limb
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_limb |=> !out_valid || limb_index == 2'd0)
        else $error("emit does not start at limb zero");

endmodule

bind bposit16_quire_dot_accumulator_unit bqda_checker #(
    .QUIRE_LIMBS (QUIRE_LIMBS)
) u_bqda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .limb_value (limb_value),
    .limb_index (limb_index),
    .last_limb  (last_limb)
);

>>> tb/sv/testbench.sv
// testbench: self-checking bench for the posit16 quire dot accumulator
// depends on bqda_pkg and bposit16_quire_dot_accumulator_unit
// predicts the quire limbs of each emitting transaction and compares them under idling and stalls
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import bqda_pkg::CODE_W;
    import bqda_pkg::LIMB_W;

    localparam int QUIRE_FRAC_BITS = 96;
    localparam int QUIRE_LIMBS     = 4;
    localparam int QUIRE_W         = LIMB_W * QUIRE_LIMBS;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 20;

    localparam logic [CODE_W-1:0] CODE_ZERO      = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_NAR       = 16'h8000;
    localparam logic [CODE_W-1:0] CODE_ONE       = 16'h4000;
    localparam logic [CODE_W-1:0] CODE_MINUS_ONE = 16'hC000;
    localparam logic [CODE_W-1:0] CODE_MAXPOS    = 16'h7FFF;
    localparam logic [CODE_W-1:0] CODE_MINPOS    = 16'h0001;
    localparam logic [CODE_W-1:0] CODE_MAXNEG    = 16'h8001;
    localparam logic [CODE_W-1:0] CODE_MINNEG    = 16'hFFFF;
    localparam logic [CODE_W-1:0] CODE_WIDE_HIGH = 16'h7F0F;

    typedef struct packed {
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        logic              clr;
        logic              emit;
    } pair_t;

    typedef struct packed {
        logic [LIMB_W-1:0] value;
        logic [1:0]        index;
        logic              last;
    } limb_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic              in_ready;
    logic [CODE_W-1:0] a_code      = '0;
    logic [CODE_W-1:0] b_code      = '0;
    logic              clear_first = 1'b0;
    logic              emit_after  = 1'b0;
    logic              out_valid;
    logic              out_ready   = 1'b0;
    logic [LIMB_W-1:0] limb_value;
    logic [1:0]        limb_index;
    logic              last_limb;

    pair_t              operand_queue[$];
    limb_t              limb_expect[$];
    logic [QUIRE_W-1:0] quire_model = '0;

    int   idle_pct      = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    logic hold_done;
    int   hold_cnt;
    int   errors        = 0;
    int   pairs_taken   = 0;
    int   limbs_checked = 0;
    int   quiet_cycles  = 0;

    bposit16_quire_dot_accumulator_unit #(
        .QUIRE_FRAC_BITS(QUIRE_FRAC_BITS),
        .QUIRE_LIMBS    (QUIRE_LIMBS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_code     (a_code),
        .b_code     (b_code),
        .clear_first(clear_first),
        .emit_after (emit_after),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .limb_value (limb_value),
        .limb_index (limb_index),
        .last_limb  (last_limb)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void posit_decode(input logic [CODE_W-1:0] code, output bit neg,
                                         output int unsigned mant, output int expo);
        logic [14:0] mag;
        logic [14:0] norm;
        logic [14:0] low;
        int          run;
        int          k;
        int          rem;
        int          ew;
        int          fw;
        int          ev;
        neg = code[15];
        mag = code[15] ? (15'd0 - code[14:0]) : code[14:0];
        if (mag == '0)
        begin
            neg  = 1'b0;
            mant = 0;
            expo = 0;
            return;
        end
        norm = mag[14] ? ~mag : mag;
        run  = 15;
        for (int i = 0; i < 15; i++)
            if (norm[i])
                run = 14 - i;
        k    = mag[14] ? run - 1 : -run;
        rem  = (run >= 14) ? 0 : 14 - run;
        ew   = (rem > 3) ? 3 : rem;
        fw   = rem - ew;
        low  = mag & ((15'd1 << rem) - 15'd1);
        ev   = int'((low >> fw) & ((15'd1 << ew) - 15'd1)) << (3 - ew);
        mant = int'(low & ((15'd1 << fw) - 15'd1)) | (1 << fw);
        expo = 8 * k + ev - fw;
    endfunction

    task automatic quire_accumulate(input pair_t p);
        bit                 neg_a;
        bit                 neg_b;
        int unsigned        mant_a;
        int unsigned        mant_b;
        int unsigned        prod;
        int                 expo_a;
        int                 expo_b;
        int                 shift;
        logic [QUIRE_W-1:0] addend;
        if (p.clr)
            quire_model = '0;
        posit_decode(p.a, neg_a, mant_a, expo_a);
        posit_decode(p.b, neg_b, mant_b, expo_b);
        prod  = mant_a * mant_b;
        shift = expo_a + expo_b + QUIRE_FRAC_BITS;
        if (prod != 0 && shift >= 0 && shift < QUIRE_W)
        begin
            addend = '0;
            addend = QUIRE_W'(prod);
            addend = addend << shift;
            if (neg_a ^ neg_b)
                addend = -addend;
            quire_model = quire_model + addend;
        end
        if (p.emit)
            for (int i = 0; i < QUIRE_LIMBS; i++)
                limb_expect.push_back('{quire_model[LIMB_W*i +: LIMB_W], 2'(i & 3),
                                        i == QUIRE_LIMBS - 1});
    endtask

    function automatic logic [CODE_W-1:0] special_code(input int sel);
        case (sel)
            0:       return CODE_ZERO;
            1:       return CODE_NAR;
            2:       return CODE_ONE;
            3:       return CODE_MINUS_ONE;
            4:       return CODE_MAXPOS;
            5:       return CODE_MINPOS;
            6:       return CODE_MAXNEG;
            7:       return CODE_MINNEG;
            default: return CODE_WIDE_HIGH;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        logic [CODE_W-1:0] c;
        case ($urandom_range(3))
            0, 1:
                c = CODE_W'($urandom);
            2:
            begin
                c = CODE_W'($urandom_range(16'h3000, 16'h4FFF));
                if ($urandom_range(1) == 1)
                    c = -c;
            end
            default:
                c = special_code($urandom_range(8));
        endcase
        return c;
    endfunction

    task automatic push_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                             input logic clr, input logic emit);
        operand_queue.push_back('{a, b, clr, emit});
    endtask

    // mostly dot-product runs (optional clear, adds, emit), the rest single items with random flags
    task automatic queue_runs(input int count);
        int left;
        int len;
        left = count;
        while (left > 0)
        begin
            if ($urandom_range(4) == 0)
            begin
                push_pair(rand_code(), rand_code(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                left--;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    push_pair(rand_code(), rand_code(), i == 0 && $urandom_range(3) != 0,
                              i == len - 1 || left == 1);
                    left--;
                end
            end
        end
    endtask

    task automatic drain();
        while (operand_queue.size() != 0 || in_valid || limb_expect.size() != 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            a_code      <= '0;
            b_code      <= '0;
            clear_first <= 1'b0;
            emit_after  <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (operand_queue.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                pair_t p;
                p = operand_queue.pop_front();
                in_valid    <= 1'b1;
                a_code      <= p.a;
                b_code      <= p.b;
                clear_first <= p.clr;
                emit_after  <= p.emit;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                quire_accumulate('{a_code, b_code, clear_first, emit_after});
                pairs_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (limb_expect.size() == 0)
                begin
                    report($sformatf("unexpected limb %0d value %h", limb_index, limb_value));
                end
                else
                begin
                    limb_t want;
                    want = limb_expect.pop_front();
                    limbs_checked++;
                    if (limb_value !== want.value)
                        report($sformatf("limb %0d value %h, expected %h", want.index,
                                         limb_value, want.value));
                    if (limb_index !== want.index)
                        report($sformatf("limb_index %0d, expected %0d", limb_index,
                                         want.index));
                    if (last_limb !== want.last)
                        report($sformatf("last_limb %b on limb %0d, expected %b", last_limb,
                                         want.index, want.last));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: signs, zero and NaR, window edges, partial overflow, wrap
        push_pair(CODE_ONE, CODE_ONE, 1'b1, 1'b1);
        push_pair(CODE_ZERO, CODE_ONE, 1'b0, 1'b1);
        push_pair(CODE_NAR, CODE_MAXPOS, 1'b0, 1'b1);
        push_pair(CODE_MAXPOS, CODE_MAXPOS, 1'b0, 1'b1);
        push_pair(CODE_MINPOS, CODE_MINPOS, 1'b0, 1'b1);
        push_pair(CODE_MINNEG, CODE_MAXPOS, 1'b0, 1'b1);
        push_pair(CODE_MAXNEG, CODE_ONE, 1'b0, 1'b1);
        push_pair(CODE_MINUS_ONE, CODE_ONE, 1'b1, 1'b1);
        push_pair(CODE_MINUS_ONE, CODE_MINUS_ONE, 1'b0, 1'b1);
        push_pair(CODE_MAXPOS, CODE_ONE, 1'b1, 1'b1);
        push_pair(CODE_WIDE_HIGH, CODE_MAXPOS, 1'b1, 1'b1);
        push_pair(CODE_WIDE_HIGH, CODE_MAXNEG, 1'b0, 1'b1);
        push_pair(CODE_WIDE_HIGH, CODE_MAXNEG, 1'b1, 1'b1);
        push_pair(16'hB123, 16'h5ABC, 1'b1, 1'b0);
        push_pair(16'h3FFF, 16'hC001, 1'b0, 1'b0);
        push_pair(16'h0FF0, 16'hF00F, 1'b0, 1'b0);
        push_pair(16'h5555, 16'hAAAA, 1'b0, 1'b1);
        push_pair(CODE_MINPOS, CODE_MAXPOS, 1'b1, 1'b1);
        push_pair(CODE_MAXNEG, CODE_MAXNEG, 1'b0, 1'b1);
        push_pair(CODE_ZERO, CODE_ZERO, 1'b1, 1'b1);
        drain();

        idle_pct  = 88;
        stall_pct = 0;
        queue_runs(24);
        drain();

        idle_pct  = 0;
        stall_pct = 88;
        queue_runs(24);
        drain();

        idle_pct  = 6;
        stall_pct = 6;
        queue_runs(24);
        drain();

        // hold the output off while emitting transactions keep coming
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        for (int i = 0; i < 12; i++)
            push_pair(rand_code(), rand_code(), i == 0, 1'b1);
        while (!hold_done)
            @(posedge clk);
        hold_req = 1'b0;
        queue_runs(10);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (limb_expect.size() != 0)
            report($sformatf("%0d expected limbs never seen", limb_expect.size()));
        $display("testbench: %0d operand pairs accepted, %0d limbs compared", pairs_taken,
                 limbs_checked);
        $display("testbench: idle and stall phases plus a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/bqda_pkg.sv
src/bqda_front.sv
src/bqda_queue.sv
src/bqda_back.sv
src/bposit16_quire_dot_accumulator_unit.sv
src/bqda_checker.sv
tb/sv/testbench.sv
